// ===== rtl/core/cbrw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbrw_pkg
// Shared widths, register indexes, reset values and the command and status
// structs between the controller and the datapath of the bin replication
// writer.
// ----------------------------------------------------------------------------
package cbrw_pkg;

   localparam int DEF_MAX_BIN_SIDE   = 8;
   localparam int DEF_MAX_FRAME_SIDE = 4096;

   localparam int SIDE_W   = 13;   // frame sides and bin counts
   localparam int BIN_W    = 4;    // bin sides
   localparam int BPP_W    = 3;
   localparam int VALUE_W  = 16;
   localparam int ADDR_W   = 26;
   localparam int CSR_A_W  = 3;
   localparam int CSR_D_W  = 13;
   localparam int MAX_BPP  = 4;

   localparam logic [CSR_A_W-1:0] REG_FRAME_WIDTH  = 3'd0;
   localparam logic [CSR_A_W-1:0] REG_FRAME_HEIGHT = 3'd1;
   localparam logic [CSR_A_W-1:0] REG_BYTES_PIXEL  = 3'd2;
   localparam logic [CSR_A_W-1:0] REG_BIN_WIDTH    = 3'd3;
   localparam logic [CSR_A_W-1:0] REG_BIN_HEIGHT   = 3'd4;
   localparam logic [CSR_A_W-1:0] REG_BINS_ACROSS  = 3'd5;
   localparam logic [CSR_A_W-1:0] REG_BINS_DOWN    = 3'd6;

   localparam logic [SIDE_W-1:0] RST_FRAME_SIDE = 13'd1024;
   localparam logic [BPP_W-1:0]  RST_BPP        = 3'd1;
   localparam logic [BIN_W-1:0]  RST_BIN_SIDE   = 4'd1;

   typedef enum logic {
      DIV_X,
      DIV_Y
   } div_sel_type;

   typedef struct packed {
      logic        div_start;
      div_sel_type div_sel;
      logic        restart;
      logic        accept;
      logic        pix_next;
      logic        bin_done;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic grid_empty;
      logic pix_last;
   } status_type;

endpackage

// ===== rtl/core/cbrw_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbrw_div
// Restoring divider, one quotient bit per cycle. Quotient is valid while
// done is high; a new start restarts it at any time.
// ----------------------------------------------------------------------------
module cbrw_div #(
   parameter int DATA_W = 13,
   parameter int DEN_W  = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DATA_W-1:0] dividend,
   input  logic [DEN_W-1:0]  divisor,
   output logic              done,
   output logic [DATA_W-1:0] quotient
);

   localparam int CNT_W = (DATA_W > 1) ? $clog2(DATA_W) : 1;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_W - 1);

   logic              busy_ff;
   logic              done_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [DATA_W-1:0] quo_ff;
   logic [DEN_W-1:0]  rem_ff;
   logic [DEN_W-1:0]  den_ff;

   logic [DEN_W:0]    rem_sh_in;
   logic              take_in;
   logic [DEN_W:0]    rem_diff_in;

   always_comb begin
      rem_sh_in   = {rem_ff, quo_ff[DATA_W-1]};
      take_in     = rem_sh_in >= {1'b0, den_ff};
      rem_diff_in = rem_sh_in - {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff  <= cnt_ff + CNT_W'(1);
         busy_ff <= cnt_ff != CNT_LAST;
         done_ff <= cnt_ff == CNT_LAST;
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         den_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[DATA_W-2:0], take_in};
         rem_ff <= take_in ? rem_diff_in[DEN_W-1:0] : rem_sh_in[DEN_W-1:0];
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/core/cbrw_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbrw_ctrl
// Sequencer: runs the set-up divisions after reset and every register
// write, lets the derived values settle, then takes one item at a time and
// steps the datapath through the pixels of its bin.
// ----------------------------------------------------------------------------
module cbrw_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output cbrw_pkg::cmd_type   cmd,
   input  cbrw_pkg::status_type status
);

   import cbrw_pkg::*;

   localparam int SETTLE_CYCLES = 7;
   localparam int SET_W = $clog2(SETTLE_CYCLES);
   localparam logic [SET_W-1:0] SETTLE_LAST = SET_W'(SETTLE_CYCLES - 1);

   typedef enum logic [2:0] {
      START_X,
      WAIT_X,
      START_Y,
      WAIT_Y,
      SETTLE,
      IDLE,
      RUN
   } state_type;

   state_type        state_ff;
   logic [SET_W-1:0] settle_ff;
   logic             req_take_in;
   logic             rsp_take_in;

   always_comb begin
      req_ready   = (state_ff == IDLE) && !csr_write;
      rsp_valid   = state_ff == RUN;
      req_take_in = req_ready && req_valid;
      rsp_take_in = rsp_valid && rsp_ready;

      cmd           = '0;
      cmd.div_start = (state_ff == START_X) || (state_ff == START_Y);
      cmd.div_sel   = ((state_ff == START_X) || (state_ff == WAIT_X)) ? DIV_X : DIV_Y;
      cmd.restart   = (state_ff == SETTLE) && (settle_ff == SETTLE_LAST);
      cmd.accept    = req_take_in;
      cmd.pix_next  = rsp_take_in;
      cmd.bin_done  = rsp_take_in && status.pix_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= START_X;
         settle_ff <= '0;
      end else if (csr_write) begin
         state_ff  <= START_X;
         settle_ff <= '0;
      end else begin
         unique case (state_ff)
            START_X: state_ff <= WAIT_X;
            WAIT_X: begin
               if (status.div_done) state_ff <= START_Y;
            end
            START_Y: state_ff <= WAIT_Y;
            WAIT_Y: begin
               if (status.div_done) begin
                  state_ff  <= SETTLE;
                  settle_ff <= '0;
               end
            end
            SETTLE: begin
               settle_ff <= settle_ff + SET_W'(1);
               if (settle_ff == SETTLE_LAST) state_ff <= IDLE;
            end
            IDLE: begin
               if (req_take_in && !status.grid_empty) state_ff <= RUN;
            end
            RUN: begin
               if (rsp_take_in && status.pix_last) state_ff <= IDLE;
            end
            default: state_ff <= START_X;
         endcase
      end
   end

endmodule

// ===== rtl/core/cbrw_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbrw_datapath
// Configuration registers, centering arithmetic, bin and pixel counters and
// the byte address walkers that drive the result item.
// ----------------------------------------------------------------------------
module cbrw_datapath #(
   parameter int MAX_BIN_SIDE   = cbrw_pkg::DEF_MAX_BIN_SIDE,
   parameter int MAX_FRAME_SIDE = cbrw_pkg::DEF_MAX_FRAME_SIDE
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write,
   input  logic [cbrw_pkg::CSR_A_W-1:0]  csr_addr,
   input  logic [cbrw_pkg::CSR_D_W-1:0]  csr_wdata,
   input  logic [cbrw_pkg::VALUE_W-1:0]  req_bin_value,
   input  cbrw_pkg::cmd_type             cmd,
   output cbrw_pkg::status_type          status,
   output logic [cbrw_pkg::ADDR_W-1:0]   rsp_byte_address,
   output logic [7:0]                    rsp_low_byte,
   output logic [7:0]                    rsp_high_byte,
   output logic                          rsp_high_valid,
   output logic                          rsp_last_in_bin,
   output logic                          rsp_last_in_frame
);

   import cbrw_pkg::*;

   localparam int PIX_W = (MAX_BIN_SIDE > 1) ? $clog2(MAX_BIN_SIDE) : 1;
   localparam logic [SIDE_W-1:0] FRAME_LIM = SIDE_W'(MAX_FRAME_SIDE);
   localparam logic [BIN_W-1:0]  BIN_LIM   = BIN_W'(MAX_BIN_SIDE);
   localparam logic [BPP_W-1:0]  BPP_LIM   = BPP_W'(MAX_BPP);

   // configuration registers
   logic [SIDE_W-1:0] fw_ff, fh_ff, ba_ff, bd_ff;
   logic [BPP_W-1:0]  bpp_ff;
   logic [BIN_W-1:0]  bw_ff, bh_ff;

   // effective values
   logic [SIDE_W-1:0] fw_in, fh_in;
   logic [BPP_W-1:0]  bpp_in;
   logic [BIN_W-1:0]  bw_in, bh_in;

   // set-up results
   logic [SIDE_W-1:0] mx_ff, my_ff, ca_ff, cd_ff;
   logic [16:0]       used_w_ff, used_h_ff;
   logic [SIDE_W-1:0] left_ff, top_rows_ff;
   logic [ADDR_W-1:0] top_ff, origin_ff, origin_b_ff;
   logic [15:0]       fw_b_ff;
   logic [5:0]        bw_b_ff;
   logic [16:0]       rowstride_ff;
   logic [ADDR_W-1:0] rowstride_b_ff;

   // walk state
   logic [SIDE_W-1:0]  bin_row_ff, bin_col_ff;
   logic [ADDR_W-1:0]  row_addr_ff, col_addr_ff, line_addr_ff, pix_addr_ff;
   logic [PIX_W-1:0]   k_ff, l_ff;
   logic [VALUE_W-1:0] value_ff;

   logic [ADDR_W-1:0] next_line_in, next_row_in;
   logic              l_end_in, k_end_in, col_end_in, row_end_in;
   logic [SIDE_W:0]   col_inc_in, row_inc_in;

   logic              div_done;
   logic [SIDE_W-1:0] div_quo;
   logic [SIDE_W-1:0] div_num_in;
   logic [BIN_W-1:0]  div_den_in;

   always_comb begin
      fw_in  = (fw_ff == '0) ? SIDE_W'(1) : ((fw_ff > FRAME_LIM) ? FRAME_LIM : fw_ff);
      fh_in  = (fh_ff == '0) ? SIDE_W'(1) : ((fh_ff > FRAME_LIM) ? FRAME_LIM : fh_ff);
      bw_in  = (bw_ff == '0) ? BIN_W'(1) : ((bw_ff > BIN_LIM) ? BIN_LIM : bw_ff);
      bh_in  = (bh_ff == '0) ? BIN_W'(1) : ((bh_ff > BIN_LIM) ? BIN_LIM : bh_ff);
      bpp_in = (bpp_ff == '0) ? BPP_W'(1) : ((bpp_ff > BPP_LIM) ? BPP_LIM : bpp_ff);

      div_num_in = (cmd.div_sel == DIV_X) ? fw_in : fh_in;
      div_den_in = (cmd.div_sel == DIV_X) ? bw_in : bh_in;

      l_end_in   = BIN_W'(l_ff) == bw_in - BIN_W'(1);
      k_end_in   = BIN_W'(k_ff) == bh_in - BIN_W'(1);
      col_inc_in = {1'b0, bin_col_ff} + (SIDE_W+1)'(1);
      row_inc_in = {1'b0, bin_row_ff} + (SIDE_W+1)'(1);
      col_end_in = col_inc_in >= {1'b0, ca_ff};
      row_end_in = row_inc_in >= {1'b0, cd_ff};

      next_line_in = line_addr_ff + ADDR_W'(fw_b_ff);
      next_row_in  = row_end_in ? origin_b_ff : row_addr_ff + rowstride_b_ff;

      status.div_done   = div_done;
      status.grid_empty = (ca_ff == '0) || (cd_ff == '0);
      status.pix_last   = l_end_in && k_end_in;
   end

   cbrw_div #(
      .DATA_W (SIDE_W),
      .DEN_W  (BIN_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_num_in),
      .divisor  (div_den_in),
      .done     (div_done),
      .quotient (div_quo)
   );

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff  <= RST_FRAME_SIDE;
         fh_ff  <= RST_FRAME_SIDE;
         bpp_ff <= RST_BPP;
         bw_ff  <= RST_BIN_SIDE;
         bh_ff  <= RST_BIN_SIDE;
         ba_ff  <= '0;
         bd_ff  <= '0;
      end else if (csr_write) begin
         unique case (csr_addr)
            REG_FRAME_WIDTH:  fw_ff  <= csr_wdata;
            REG_FRAME_HEIGHT: fh_ff  <= csr_wdata;
            REG_BYTES_PIXEL:  bpp_ff <= csr_wdata[BPP_W-1:0];
            REG_BIN_WIDTH:    bw_ff  <= csr_wdata[BIN_W-1:0];
            REG_BIN_HEIGHT:   bh_ff  <= csr_wdata[BIN_W-1:0];
            REG_BINS_ACROSS:  ba_ff  <= csr_wdata;
            REG_BINS_DOWN:    bd_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // centering arithmetic, registered stage by stage from the division results
   always_ff @(posedge clock) begin
      if (div_done && (cmd.div_sel == DIV_X)) mx_ff <= div_quo;
      if (div_done && (cmd.div_sel == DIV_Y)) my_ff <= div_quo;
      ca_ff          <= (ba_ff < mx_ff) ? ba_ff : mx_ff;
      cd_ff          <= (bd_ff < my_ff) ? bd_ff : my_ff;
      used_w_ff      <= 17'(ca_ff * bw_in);
      used_h_ff      <= 17'(cd_ff * bh_in);
      left_ff        <= SIDE_W'((17'(fw_in) - used_w_ff) >> 1);
      top_rows_ff    <= SIDE_W'((17'(fh_in) - used_h_ff) >> 1);
      top_ff         <= ADDR_W'(top_rows_ff * fw_in);
      origin_ff      <= top_ff + ADDR_W'(left_ff);
      origin_b_ff    <= ADDR_W'(origin_ff * bpp_in);
      fw_b_ff        <= 16'(fw_in * bpp_in);
      bw_b_ff        <= 6'(bw_in * bpp_in);
      rowstride_ff   <= 17'(fw_in * bh_in);
      rowstride_b_ff <= ADDR_W'(rowstride_ff * bpp_in);
   end

   // bin position
   always_ff @(posedge clock) begin
      if (reset) begin
         bin_row_ff <= '0;
         bin_col_ff <= '0;
      end else if (cmd.restart) begin
         bin_row_ff <= '0;
         bin_col_ff <= '0;
      end else if (cmd.bin_done) begin
         if (col_end_in) begin
            bin_col_ff <= '0;
            bin_row_ff <= row_end_in ? '0 : row_inc_in[SIDE_W-1:0];
         end else begin
            bin_col_ff <= col_inc_in[SIDE_W-1:0];
         end
      end
   end

   // address walkers
   always_ff @(posedge clock) begin
      if (cmd.restart) begin
         row_addr_ff <= origin_b_ff;
         col_addr_ff <= origin_b_ff;
      end else if (cmd.bin_done) begin
         if (col_end_in) begin
            row_addr_ff <= next_row_in;
            col_addr_ff <= next_row_in;
         end else begin
            col_addr_ff <= col_addr_ff + ADDR_W'(bw_b_ff);
         end
      end

      if (cmd.accept) begin
         value_ff     <= req_bin_value;
         pix_addr_ff  <= col_addr_ff;
         line_addr_ff <= col_addr_ff;
         k_ff         <= '0;
         l_ff         <= '0;
      end else if (cmd.pix_next && !status.pix_last) begin
         if (l_end_in) begin
            l_ff         <= '0;
            k_ff         <= k_ff + PIX_W'(1);
            line_addr_ff <= next_line_in;
            pix_addr_ff  <= next_line_in;
         end else begin
            l_ff        <= l_ff + PIX_W'(1);
            pix_addr_ff <= pix_addr_ff + ADDR_W'(bpp_in);
         end
      end
   end

   assign rsp_byte_address  = pix_addr_ff;
   assign rsp_low_byte      = value_ff[7:0];
   assign rsp_high_valid    = bpp_in > BPP_W'(1);
   assign rsp_high_byte     = rsp_high_valid ? value_ff[15:8] : 8'd0;
   assign rsp_last_in_bin   = status.pix_last;
   assign rsp_last_in_frame = status.pix_last && col_end_in && row_end_in;

endmodule

// ===== rtl/core/centered_bin_replication_writer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// centered_bin_replication_writer
// Replicates each bin value over a bin_width by bin_height block of a frame
// buffer, with the bin grid centered in the frame, one pixel write per item.
//
//   channel   direction  handshake             payload
//   req_      in         req_valid/req_ready   bin_value
//   rsp_      out        rsp_valid/rsp_ready   byte_address, bytes, flags
//   csr_      in         csr_valid/csr_ready   csr_addr, csr_wdata
//
// one item gives bin_width * bin_height result items (up to 64 at the
// default MAX_BIN_SIDE), one per cycle while rsp_ready is high; the
// controller returns to IDLE before the next item is taken. after reset
// and after each register write a set-up pass (two divisions and a
// settle) runs with req_ready low. a write to an unknown index
// changes nothing. a stalled rsp_ready holds the current pixel in place.
// ----------------------------------------------------------------------------
module centered_bin_replication_writer #(
   parameter int MAX_BIN_SIDE   = cbrw_pkg::DEF_MAX_BIN_SIDE,
   parameter int MAX_FRAME_SIDE = cbrw_pkg::DEF_MAX_FRAME_SIDE
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [cbrw_pkg::CSR_A_W-1:0]  csr_addr,
   input  logic [cbrw_pkg::CSR_D_W-1:0]  csr_wdata,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [cbrw_pkg::VALUE_W-1:0]  req_bin_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [cbrw_pkg::ADDR_W-1:0]   rsp_byte_address,
   output logic [7:0]                    rsp_low_byte,
   output logic [7:0]                    rsp_high_byte,
   output logic                          rsp_high_valid,
   output logic                          rsp_last_in_bin,
   output logic                          rsp_last_in_frame
);

   import cbrw_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       csr_write;
   logic       csr_known;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign csr_known = csr_write && (csr_addr <= REG_BINS_DOWN);

   cbrw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_known),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   cbrw_datapath #(
      .MAX_BIN_SIDE   (MAX_BIN_SIDE),
      .MAX_FRAME_SIDE (MAX_FRAME_SIDE)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_write         (csr_write),
      .csr_addr          (csr_addr),
      .csr_wdata         (csr_wdata),
      .req_bin_value     (req_bin_value),
      .cmd               (cmd),
      .status            (status),
      .rsp_byte_address  (rsp_byte_address),
      .rsp_low_byte      (rsp_low_byte),
      .rsp_high_byte     (rsp_high_byte),
      .rsp_high_valid    (rsp_high_valid),
      .rsp_last_in_bin   (rsp_last_in_bin),
      .rsp_last_in_frame (rsp_last_in_frame)
   );

endmodule
